[hw/rtl/obstacle_inflation_dilation_defines.svh]
// Assertion macros used by the checker of the dilation block.
// They expect clk and rst_n in scope.
`ifndef OBSTACLE_INFLATION_DILATION_DEFINES_SVH
`define OBSTACLE_INFLATION_DILATION_DEFINES_SVH

// same-cycle implication
`define OID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/oid_pkg.sv]
package oid_pkg;

  localparam int COL_W  = 11;
  localparam int ROW_W  = 13;
  localparam int HGT_W  = 12;
  localparam int AGE_W  = 4;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 12;

  localparam logic [AGE_W-1:0] AGE_SAT   = 4'd15;
  localparam logic [7:0]       MASK_FREE = 8'd255;
  localparam logic [7:0]       MASK_OCC  = 8'd0;

  localparam logic [COL_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [HGT_W-1:0] HEIGHT_RST = 12'd1024;

  typedef enum logic [CFG_IW-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mask_value;
    logic       last_pixel;
  } out_item_t;

  function automatic logic [AGE_W-1:0] sat_inc(input logic [AGE_W-1:0] v);
    return (v == AGE_SAT) ? AGE_SAT : v + AGE_W'(1);
  endfunction

endpackage

[hw/rtl/oid_age_ram.sv]
module oid_age_ram
  import oid_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [AGE_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [AGE_W-1:0] rdata
);

  logic [AGE_W-1:0] mem [DEPTH];
  logic [AGE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/obstacle_inflation_dilation.sv]
// Channel  | Direction | Handshake            | Beat
// ---------+-----------+----------------------+-----------------------------------
// in_      | in        | in_valid / in_ready  | one pixel: red, green, blue
// out_     | out       | out_valid / out_ready| mask_value, last_pixel
// cfg_     | in        | cfg_valid / cfg_ready| register index and write data
//
// One pixel beat per cycle unless stalled; a result passes the work stage, then
// the result register. The age store is read at accept and, for image columns,
// written when the pixel leaves the work stage. After reset a clearing pass fills
// the age store; in_ready stays low during it, config writes are taken throughout.
// Stalls on out_ready back up through the single work stage to in_ready.
module obstacle_inflation_dilation
  import oid_pkg::*;
#(
  parameter int RADIUS    = 6,
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [COL_W:0]     MaxW    = (COL_W+1)'(MAX_WIDTH);
  localparam logic [COL_W:0]     RadW    = (COL_W+1)'(RADIUS);
  localparam logic [ROW_W-1:0]   RadR    = ROW_W'(RADIUS);
  localparam logic [COL_W-1:0]   RadC    = COL_W'(RADIUS);
  localparam logic [AGE_W-1:0]   HitMax  = AGE_W'(2 * RADIUS);
  localparam logic [AW-1:0]      ClrLast = AW'(MAX_WIDTH - 1);

  logic [COL_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [AGE_W-1:0] csh_r, csh_nxt;

  logic             clr_active_r;
  logic [AW-1:0]    clr_cnt_r;

  logic             s1_valid_r;
  logic             s1_obst_r;
  logic             s1_row0_r;
  logic             s1_we_r;
  logic [AW-1:0]    s1_addr_r;
  logic             s1_col0_r;
  logic             s1_res_r;
  logic             s1_last_r;

  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             accept, s1_move;
  logic [COL_W:0]   w0, eff_w, wext, c_inc;
  logic [HGT_W-1:0] eff_h;
  logic [ROW_W-1:0] hext;
  logic [ROW_W:0]   r_inc;
  logic             end_row, end_frame, in_col, in_image, obstacle;

  logic [AGE_W-1:0] rd_age, old_age, age;
  logic             col_hit;
  logic [AGE_W-1:0] prev_csh;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AGE_W-1:0] ram_wdata;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[COL_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept side: position bookkeeping
  always_comb begin
    w0    = (width_r == '0) ? (COL_W+1)'(1) : {1'b0, width_r};
    eff_w = (w0 > MaxW) ? MaxW : w0;
    eff_h = (height_r == '0) ? HGT_W'(1) : height_r;
    wext  = eff_w + RadW;
    hext  = {1'b0, eff_h} + RadR;
    c_inc = {1'b0, col_r} + (COL_W+1)'(1);
    r_inc = {1'b0, row_r} + (ROW_W+1)'(1);
    end_row   = c_inc >= wext;
    end_frame = end_row && (r_inc >= {1'b0, hext});
    in_col    = {1'b0, col_r} < eff_w;
    in_image  = row_r < {1'b0, eff_h};
    obstacle  = in_image && ((in_data.red == 8'd0) || (in_data.green == 8'd0) ||
                             (in_data.blue == 8'd0));
    if (end_row) begin
      col_nxt = '0;
      row_nxt = end_frame ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_nxt = c_inc[COL_W-1:0];
      row_nxt = row_r;
    end
  end

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_active_r && (!s1_valid_r || s1_move);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      col_r        <= '0;
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else begin
      if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == ClrLast) begin
          clr_active_r <= 1'b0;
        end
      end
    end
  end

  // Work stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_obst_r <= obstacle;
      s1_row0_r <= (row_r == '0);
      s1_we_r   <= in_col;
      s1_addr_r <= col_r[AW-1:0];
      s1_col0_r <= (col_r == '0);
      s1_res_r  <= (row_r >= RadR) && (col_r >= RadC);
      s1_last_r <= end_frame;
    end
  end

  oid_age_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_age_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col_r[AW-1:0]),
    .rdata (rd_age)
  );

  always_comb begin
    old_age  = s1_row0_r ? AGE_SAT : rd_age;
    age      = s1_obst_r ? '0 : sat_inc(old_age);
    col_hit  = s1_we_r && (age <= HitMax);
    prev_csh = s1_col0_r ? AGE_SAT : csh_r;
    csh_nxt  = col_hit ? '0 : sat_inc(prev_csh);
  end

  // clearing pass owns the write port until it ends
  assign ram_we    = clr_active_r || (s1_move && s1_we_r);
  assign ram_waddr = clr_active_r ? clr_cnt_r : s1_addr_r;
  assign ram_wdata = clr_active_r ? AGE_SAT : age;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csh_r <= AGE_SAT;
    end else if (s1_move) begin
      csh_r <= csh_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= s1_res_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.mask_value <= (csh_nxt <= HitMax) ? MASK_OCC : MASK_FREE;
      out_data_r.last_pixel <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/oid_checker.sv]
`include "obstacle_inflation_dilation_defines.svh"

module oid_checker
  import oid_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input out_item_t         out_data
);

  logic out_held;
  logic in_beat;
  logic mask_ok;

  assign out_held = out_valid && !out_ready;
  assign in_beat  = in_valid && in_ready;
  assign mask_ok  = (out_data.mask_value == MASK_OCC) || (out_data.mask_value == MASK_FREE);

  // a stalled result beat holds
  `OID_ASSERT_NXT(a_out_hold, out_held, out_valid && $stable(out_data), "stalled beat changed")

  `OID_ASSERT_IMP(a_mask_code, out_valid, mask_ok, "mask value is neither occupied nor free")

  // the age store is being cleared right after reset
  `OID_ASSERT_IMP(a_clear_blocks, $past(!rst_n), !in_ready, "pixel taken before the clear pass")

  // a fresh result needs a pixel taken before it
  `OID_ASSERT_IMP(a_out_cause, $rose(out_valid), $past(in_beat, 2), "result without a pixel beat")

endmodule

bind obstacle_inflation_dilation oid_checker u_oid_checker (.*);

[bench/tb_obstacle_inflation_dilation.sv]
module tb_obstacle_inflation_dilation;
  import oid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAD         = 6;
  localparam int MAX_W       = 1024;
  localparam int MAX_AW      = $clog2(MAX_W);
  localparam int RAND_BEATS  = 150;
  localparam int SAT_BEATS   = 100;
  localparam int SETTLE      = 8;
  localparam int SQUEEZE_LEN = 300;
  localparam int SQUEEZE_Q   = 16;
  localparam int CYCLE_LIMIT = 1000000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data  = '0;

  obstacle_inflation_dilation i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Mirror of the block state
  logic [COL_W-1:0] width_reg  = WIDTH_RST;
  logic [HGT_W-1:0] height_reg = HEIGHT_RST;
  logic [AGE_W-1:0] col_age [MAX_W];
  logic [ROW_W-1:0] row_pos    = '0;
  logic [COL_W-1:0] col_pos    = '0;
  logic [AGE_W-1:0] run_len    = AGE_SAT;

  in_item_t  pixel_q [$];
  out_item_t mask_q [$];

  int  mismatches    = 0;
  int  cycle_count   = 0;
  int  in_idle_pct   = 0;
  int  out_idle_pct  = 0;
  int  in_gap        = 0;
  int  out_stall     = 0;
  int  hold_left     = 0;
  bit  squeeze_armed = 1'b0;
  bit  squeeze_done  = 1'b0;

  function automatic int eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return int'(width_reg);
  endfunction

  function automatic int eff_h();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic logic [AGE_W-1:0] age_step(logic [AGE_W-1:0] v);
    return (v == AGE_SAT) ? AGE_SAT : v + 1'b1;
  endfunction

  function automatic void queue_pixel(in_item_t p);
    pixel_q.insert(pixel_q.size(), p);
  endfunction

  // Advance the mirror by one pixel beat and queue its mask if it lies in the result window.
  function automatic void inflate_pixel(in_item_t px);
    int               w, h, wext, hext;
    logic             blocked, hit, end_row, end_frame;
    logic [AGE_W-1:0] old_age, age, prev_run;
    out_item_t        res;
    w    = eff_w();
    h    = eff_h();
    wext = w + RAD;
    hext = h + RAD;
    hit  = 1'b0;
    if (col_pos < w) begin
      blocked = (row_pos < h) && (px.red == 0 || px.green == 0 || px.blue == 0);
      // ignore stale column history on the first row of a frame
      old_age = (row_pos == 0) ? AGE_SAT : col_age[col_pos[MAX_AW-1:0]];
      age = blocked ? '0 : age_step(old_age);
      col_age[col_pos[MAX_AW-1:0]] = age;
      hit = (age <= 2 * RAD);
    end
    prev_run = (col_pos == 0) ? AGE_SAT : run_len;
    run_len  = hit ? '0 : age_step(prev_run);
    end_row   = int'(col_pos) + 1 >= wext;
    end_frame = end_row && (int'(row_pos) + 1 >= hext);
    if (row_pos >= RAD && col_pos >= RAD) begin
      res.mask_value = (run_len <= 2 * RAD) ? MASK_OCC : MASK_FREE;
      res.last_pixel = end_frame;
      mask_q.insert(mask_q.size(), res);
    end
    if (end_row) begin
      col_pos = '0;
      row_pos = end_frame ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic int beats_to_frame_end();
    int r, c, n, wext, hext;
    bit done;
    r    = int'(row_pos);
    c    = int'(col_pos);
    n    = 0;
    done = 1'b0;
    wext = eff_w() + RAD;
    hext = eff_h() + RAD;
    do begin
      n++;
      if (c + 1 >= wext) begin
        if (r + 1 >= hext) done = 1'b1;
        c = 0;
        r = (r + 1) % (1 << ROW_W);
      end else begin
        c = (c + 1) % (1 << COL_W);
      end
    end while (!done);
    return n;
  endfunction

  function automatic in_item_t clear_pixel();
    in_item_t p;
    p.red   = 8'($urandom_range(255, 1));
    p.green = 8'($urandom_range(255, 1));
    p.blue  = 8'($urandom_range(255, 1));
    return p;
  endfunction

  function automatic in_item_t blocked_pixel(int ch);
    in_item_t p;
    p.red   = 8'($urandom_range(255));
    p.green = 8'($urandom_range(255));
    p.blue  = 8'($urandom_range(255));
    case (ch)
      0:       p.red   = '0;
      1:       p.green = '0;
      default: p.blue  = '0;
    endcase
    return p;
  endfunction

  function automatic in_item_t any_pixel(int pct);
    if ($urandom_range(99) < pct) return blocked_pixel($urandom_range(2));
    return clear_pixel();
  endfunction

  function automatic int pick_density();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 3;
      2:       return 10;
      3:       return 30;
      4:       return 70;
      default: return 100;
    endcase
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    $display("mask mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (mask_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected beat mask_value=%0d last_pixel=%0b",
                              got.mask_value, got.last_pixel));
    end else begin
      want = mask_q.pop_front();
      if (got.mask_value !== want.mask_value)
        flag_mismatch($sformatf("mask_value got %0d want %0d",
                                got.mask_value, want.mask_value));
      if (got.last_pixel !== want.last_pixel)
        flag_mismatch($sformatf("last_pixel got %0b want %0b",
                                got.last_pixel, want.last_pixel));
    end
  endtask

  // Pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) inflate_pixel(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          in_data  <= pixel_q.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(99) < in_idle_pct) in_gap = $urandom_range(15, 1);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started while a result waits and pixels keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (squeeze_armed && !squeeze_done && out_valid &&
                 pixel_q.size() >= SQUEEZE_Q) begin
      // hold off long enough to back the block up into in_ready
      squeeze_done = 1'b1;
      hold_left    = SQUEEZE_LEN;
    end
  end

  // Mask monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(99) < out_idle_pct) out_stall = $urandom_range(15, 1);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("obstacle_inflation_dilation verification failed");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk); while (pixel_q.size() != 0 || in_valid || mask_q.size() != 0);
    // let padding beats that carry no mask drain out
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = val[COL_W-1:0];
    else if (idx == CFG_IMAGE_HEIGHT) height_reg = val[HGT_W-1:0];
    @(negedge clk);
  endtask

  // Queue one whole frame from the frame start; at most one marked image pixel is an obstacle.
  task automatic push_marked_frame(int mr, int mc, int ch);
    int wi, hi;
    wi = eff_w();
    hi = eff_h();
    for (int r = 0; r < hi + RAD; r++) begin
      for (int c = 0; c < wi + RAD; c++) begin
        if (r < hi && c < wi)
          queue_pixel((r == mr && c == mc) ? blocked_pixel(ch) : clear_pixel());
        else
          queue_pixel(any_pixel(50));
      end
    end
  endtask

  initial begin
    int  rand_beats;
    int  n;
    int  pct;
    int  sel;
    logic [CFG_DW-1:0] w_val, h_val;
    rand_beats = 0;
    foreach (col_age[i]) col_age[i] = AGE_SAT;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames: zero sizes, each channel, window edges
    in_idle_pct   = 15;
    out_idle_pct  = 15;
    squeeze_armed = 1'b1;
    write_reg(CFG_IMAGE_WIDTH, '0);
    write_reg(CFG_IMAGE_HEIGHT, '0);
    push_marked_frame(0, 0, 0);
    push_marked_frame(-1, -1, 0);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 12'd2);
    write_reg(CFG_IMAGE_HEIGHT, 12'd2);
    push_marked_frame(0, 1, 2);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 12'd8);
    write_reg(CFG_IMAGE_HEIGHT, 12'd1);
    push_marked_frame(0, 0, 1);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 12'd1);
    write_reg(CFG_IMAGE_HEIGHT, 12'd8);
    push_marked_frame(0, 0, 0);
    wait_idle();

    // Walk the leading rows narrow, then widen to full width mid-frame
    write_reg(CFG_IMAGE_HEIGHT, 12'hFFF);
    repeat (RAD * (1 + RAD)) queue_pixel(any_pixel(30));
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 12'd1024);
    repeat ((MAX_W + RAD) / 2) queue_pixel(any_pixel(5));
    wait_idle();
    // out-of-range width saturates, the row keeps going
    write_reg(CFG_IMAGE_WIDTH, 12'hFFF);
    repeat (SAT_BEATS) queue_pixel(any_pixel(5));
    wait_idle();
    // shrink both sizes so the frame wraps at the end of this row
    write_reg(CFG_IMAGE_WIDTH, 12'd1);
    write_reg(CFG_IMAGE_HEIGHT, 12'd1);
    n = beats_to_frame_end();
    repeat (n) queue_pixel(any_pixel(50));

    // Random frames, some cut short so the next settings land mid-frame
    while (rand_beats < RAND_BEATS) begin
      wait_idle();
      in_idle_pct  = pick_idle();
      out_idle_pct = pick_idle();
      w_val = ($urandom_range(4) == 0) ? CFG_DW'($urandom_range(40, 13))
                                       : CFG_DW'($urandom_range(12, 1));
      h_val = ($urandom_range(5) == 0) ? CFG_DW'($urandom_range(20, 11))
                                       : CFG_DW'($urandom_range(10, 1));
      sel = $urandom_range(5);
      if ($urandom_range(1)) begin
        if (sel != 1) write_reg(CFG_IMAGE_WIDTH, w_val);
        if (sel != 2) write_reg(CFG_IMAGE_HEIGHT, h_val);
      end else begin
        if (sel != 2) write_reg(CFG_IMAGE_HEIGHT, h_val);
        if (sel != 1) write_reg(CFG_IMAGE_WIDTH, w_val);
      end
      pct = pick_density();
      n = beats_to_frame_end();
      if ($urandom_range(5) == 0) n = $urandom_range(n, 1);
      if (n > RAND_BEATS - rand_beats) n = RAND_BEATS - rand_beats;
      repeat (n) queue_pixel(any_pixel(pct));
      rand_beats += n;
    end

    // Closing frame at full rate
    wait_idle();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    in_gap       = 0;
    out_stall    = 0;
    write_reg(CFG_IMAGE_WIDTH, CFG_DW'($urandom_range(12, 1)));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DW'($urandom_range(10, 1)));
    n = beats_to_frame_end();
    repeat (n) queue_pixel(any_pixel(20));
    wait_idle();

    if (mismatches == 0) begin
      $display("obstacle_inflation_dilation verification clean");
    end else begin
      $display("obstacle_inflation_dilation verification failed");
    end
    $finish;
  end

endmodule
